// ===== rtl/core/q2e_pkg.sv =====
package q2e_pkg;

	localparam int unsigned CORDIC_STAGES_DEF = 16;
	localparam int unsigned TABLE_LEN = 24;

	localparam int unsigned QW = 16;
	localparam int unsigned PW = 32;
	localparam int unsigned VW = 35;
	localparam int unsigned CW = 38;
	localparam int unsigned ZW = 27;
	localparam int unsigned SB = 29;
	localparam int unsigned RW = 57;

	localparam logic signed [VW-1:0] ONE_Q28 = VW'(64'd1 << 28);
	localparam logic signed [ZW-1:0] DEG180_Q16 = ZW'(180 * 65536);
	localparam logic signed [ZW-1:0] ROLL_LIM = ZW'(23040);
	localparam logic signed [ZW-1:0] PITCH_LIM = ZW'(11520);

	localparam logic signed [ZW-1:0] ATAN_Q16 [TABLE_LEN] = '{
		27'sd2949120, 27'sd1740967, 27'sd919879, 27'sd466945,
		27'sd234379, 27'sd117304, 27'sd58665, 27'sd29335,
		27'sd14668, 27'sd7334, 27'sd3667, 27'sd1833,
		27'sd917, 27'sd458, 27'sd229, 27'sd115,
		27'sd57, 27'sd29, 27'sd14, 27'sd7,
		27'sd4, 27'sd2, 27'sd1, 27'sd0
	};

	typedef struct packed {
		logic signed [VW-1:0] roll_x;
		logic signed [VW-1:0] roll_y;
		logic signed [VW-1:0] yaw_x;
		logic signed [VW-1:0] yaw_y;
		logic signed [SB-1:0] s;
		logic                 clamp;
		logic                 neg;
	} pass_t;

	typedef struct packed {
		logic signed [CW-1:0] x;
		logic signed [CW-1:0] y;
		logic signed [ZW-1:0] z;
	} vec_t;

	// fold left half plane into the right one
	function automatic vec_t cordic_pre(input logic signed [CW-1:0] x,
			input logic signed [CW-1:0] y);
		vec_t v;
		v.x = x;
		v.y = y;
		v.z = '0;
		if (x < 0) begin
			v.z = (y >= 0) ? DEG180_Q16 : -DEG180_Q16;
			v.x = -x;
			v.y = -y;
		end
		return v;
	endfunction

	// Q16 degrees to Q7, round half up, saturate
	function automatic logic signed [15:0] sat_q7(input logic signed [ZW-1:0] z,
			input logic signed [ZW-1:0] lim);
		logic signed [ZW-1:0] d;
		d = (z + ZW'(256)) >>> 9;
		if (d > lim)
			d = lim;
		if (d < -lim)
			d = -lim;
		return d[15:0];
	endfunction

endpackage

// ===== rtl/core/q2e_sqrt_cell.sv =====
module q2e_sqrt_cell import q2e_pkg::*; #(
	parameter int unsigned BIT = 0
) (
	input  logic          clk,
	input  logic          en,
	input  logic [RW-1:0] rem_i,
	input  logic [SB-1:0] root_i,
	input  pass_t         pass_i,
	output logic [RW-1:0] rem_o,
	output logic [SB-1:0] root_o,
	output pass_t         pass_o
);

	logic [RW+1:0] trial;

	assign trial = ((RW+2)'(root_i) << (BIT + 1)) + ((RW+2)'(1) << (2 * BIT));

	always_ff @(posedge clk) begin
		if (en) begin
			pass_o <= pass_i;
			if ({2'b00, rem_i} >= trial) begin
				rem_o  <= rem_i - trial[RW-1:0];
				root_o <= root_i | (SB'(1) << BIT);
			end else begin
				rem_o  <= rem_i;
				root_o <= root_i;
			end
		end
	end

endmodule

// ===== rtl/core/q2e_cordic_cell.sv =====
module q2e_cordic_cell import q2e_pkg::*; #(
	parameter int unsigned STAGE = 0
) (
	input  logic clk,
	input  logic en,
	input  vec_t vec_i,
	output vec_t vec_o
);

	logic signed [CW-1:0] xs, ys;

	assign xs = vec_i.x >>> STAGE;
	assign ys = vec_i.y >>> STAGE;

	always_ff @(posedge clk) begin
		if (en) begin
			if (vec_i.y > 0) begin
				vec_o.x <= vec_i.x + ys;
				vec_o.y <= vec_i.y - xs;
				vec_o.z <= vec_i.z + ATAN_Q16[STAGE];
			end else if (vec_i.y < 0) begin
				vec_o.x <= vec_i.x - ys;
				vec_o.y <= vec_i.y + xs;
				vec_o.z <= vec_i.z - ATAN_Q16[STAGE];
			end else begin
				vec_o <= vec_i;
			end
		end
	end

endmodule

// ===== rtl/core/quaternion_to_euler_angles.sv =====
// Throughput: one beat per cycle while the output is not stalled; the pipe holds
// 3 product/sum stages, 29 square root cells, one quadrant fold stage,
// CORDIC_STAGES vectoring cells, one output register.
// The whole pipe advances when the output register is empty or taken.
// Reset (arst_n low, asynchronous) clears only the valid bits.
module quaternion_to_euler_angles import q2e_pkg::*; #(
	parameter int unsigned CORDIC_STAGES = CORDIC_STAGES_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_stall,
	input  logic signed [15:0]   quat_x,
	input  logic signed [15:0]   quat_y,
	input  logic signed [15:0]   quat_z,
	input  logic signed [15:0]   quat_w,
	output logic                 out_valid,
	input  logic                 out_stall,
	output logic signed [15:0]   roll_deg,
	output logic signed [14:0]   pitch_deg,
	output logic signed [15:0]   yaw_deg,
	output logic                 pitch_clamped
);

	localparam int unsigned N  = CORDIC_STAGES;
	localparam int unsigned NV = 4 + SB + N;

	logic en;
	logic [NV-1:0] vld_q;
	logic out_valid_q;

	logic signed [PW-1:0] p_wx_s1, p_yz_s1, p_xx_s1, p_yy_s1, p_wz_s1;
	logic signed [PW-1:0] p_xy_s1, p_zz_s1, p_wy_s1, p_zx_s1;
	logic signed [VW-1:0] roll_x_s2, roll_y_s2, yaw_x_s2, yaw_y_s2, s_s2;
	pass_t pass_s3;
	logic [2*(SB-1)-1:0] ss_s3;
	logic signed [SB-1:0] s29;
	logic signed [2*SB-1:0] sq;
	logic clamp_nx;

	logic [RW-1:0] rem_w [0:SB];
	logic [SB-1:0] root_w [0:SB];
	pass_t pass_w [0:SB];

	vec_t rv [0:N];
	vec_t pv [0:N];
	vec_t yv [0:N];
	logic [1:0] spec_q [0:N];

	logic signed [15:0] roll_nx, yaw_nx, pitch_full;
	logic signed [14:0] pitch_nx;

	assign en = !out_valid_q || !out_stall;
	assign in_stall = !en;
	assign out_valid = out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
			out_valid_q <= 1'b0;
		end else if (en) begin
			vld_q <= {vld_q[NV-2:0], in_valid};
			out_valid_q <= vld_q[NV-1];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			p_wx_s1 <= quat_w * quat_x;
			p_yz_s1 <= quat_y * quat_z;
			p_xx_s1 <= quat_x * quat_x;
			p_yy_s1 <= quat_y * quat_y;
			p_wz_s1 <= quat_w * quat_z;
			p_xy_s1 <= quat_x * quat_y;
			p_zz_s1 <= quat_z * quat_z;
			p_wy_s1 <= quat_w * quat_y;
			p_zx_s1 <= quat_z * quat_x;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			roll_y_s2 <= (VW'(p_wx_s1) + VW'(p_yz_s1)) <<< 1;
			roll_x_s2 <= ONE_Q28 - ((VW'(p_xx_s1) + VW'(p_yy_s1)) <<< 1);
			yaw_y_s2  <= (VW'(p_wz_s1) + VW'(p_xy_s1)) <<< 1;
			yaw_x_s2  <= ONE_Q28 - ((VW'(p_yy_s1) + VW'(p_zz_s1)) <<< 1);
			s_s2      <= (VW'(p_wy_s1) - VW'(p_zx_s1)) <<< 1;
		end
	end

	always_comb begin
		s29 = s_s2[SB-1:0];
		sq = s29 * s29;
		clamp_nx = (s_s2 >= ONE_Q28) || (s_s2 <= -ONE_Q28);
	end

	always_ff @(posedge clk) begin
		if (en) begin
			pass_s3.roll_x <= roll_x_s2;
			pass_s3.roll_y <= roll_y_s2;
			pass_s3.yaw_x  <= yaw_x_s2;
			pass_s3.yaw_y  <= yaw_y_s2;
			pass_s3.s      <= s29;
			pass_s3.clamp  <= clamp_nx;
			pass_s3.neg    <= s_s2[VW-1];
			ss_s3          <= clamp_nx ? '0 : sq[2*(SB-1)-1:0];
		end
	end

	assign rem_w[0]  = (RW'(1) << (2 * (SB - 1))) - RW'(ss_s3);
	assign root_w[0] = '0;
	assign pass_w[0] = pass_s3;

	for (genvar k = 0; k < SB; k++) begin : g_sqrt
		q2e_sqrt_cell #(.BIT(SB - 1 - k)) u_cell (
			.clk    (clk),
			.en     (en),
			.rem_i  (rem_w[k]),
			.root_i (root_w[k]),
			.pass_i (pass_w[k]),
			.rem_o  (rem_w[k+1]),
			.root_o (root_w[k+1]),
			.pass_o (pass_w[k+1])
		);
	end

	always_ff @(posedge clk) begin
		if (en) begin
			rv[0] <= cordic_pre(CW'(pass_w[SB].roll_x), CW'(pass_w[SB].roll_y));
			yv[0] <= cordic_pre(CW'(pass_w[SB].yaw_x), CW'(pass_w[SB].yaw_y));
			pv[0] <= cordic_pre($signed(CW'({1'b0, root_w[SB]})), CW'(pass_w[SB].s));
			spec_q[0] <= {pass_w[SB].clamp, pass_w[SB].neg};
			for (int i = 0; i < N; i++)
				spec_q[i+1] <= spec_q[i];
		end
	end

	for (genvar i = 0; i < N; i++) begin : g_cordic
		q2e_cordic_cell #(.STAGE(i)) u_roll (
			.clk (clk), .en (en), .vec_i (rv[i]), .vec_o (rv[i+1])
		);
		q2e_cordic_cell #(.STAGE(i)) u_pitch (
			.clk (clk), .en (en), .vec_i (pv[i]), .vec_o (pv[i+1])
		);
		q2e_cordic_cell #(.STAGE(i)) u_yaw (
			.clk (clk), .en (en), .vec_i (yv[i]), .vec_o (yv[i+1])
		);
	end

	always_comb begin
		roll_nx = sat_q7(rv[N].z, ROLL_LIM);
		yaw_nx = sat_q7(yv[N].z, ROLL_LIM);
		pitch_full = sat_q7(pv[N].z, PITCH_LIM);
		if (spec_q[N][1])
			pitch_nx = spec_q[N][0] ? -15'sd11520 : 15'sd11520;
		else
			pitch_nx = pitch_full[14:0];
	end

	always_ff @(posedge clk) begin
		if (en) begin
			roll_deg      <= roll_nx;
			yaw_deg       <= yaw_nx;
			pitch_deg     <= pitch_nx;
			pitch_clamped <= spec_q[N][1];
		end
	end

	a_clamp_value: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && pitch_clamped |-> pitch_deg == 15'sd11520 || pitch_deg == -15'sd11520)
		else $error("clamped pitch not at +/-90 degrees");

	a_roll_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> roll_deg <= 16'sd23040 && roll_deg >= -16'sd23040)
		else $error("roll out of range");

	a_yaw_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> yaw_deg <= 16'sd23040 && yaw_deg >= -16'sd23040)
		else $error("yaw out of range");

	a_stall_src: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall == (out_valid && out_stall))
		else $error("input stall not tied to held output beat");

endmodule

// ===== tb/sv/quaternion_to_euler_angles_tb.sv =====
`timescale 1ns / 1ps

module quaternion_to_euler_angles_tb;
	import q2e_pkg::*;

	localparam int unsigned STAGES = CORDIC_STAGES_DEF;
	localparam int N_RAND = 1450;

	typedef struct {
		logic signed [15:0] x, y, z, w;
	} quat_t;

	typedef struct {
		logic signed [15:0] roll;
		logic signed [14:0] pitch;
		logic signed [15:0] yaw;
		logic               clamp;
	} euler_t;

	typedef struct {
		quat_t  q;
		bit     has_exp;
		euler_t e;
	} row_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_stall;
	logic signed [15:0] quat_x = '0, quat_y = '0, quat_z = '0, quat_w = '0;
	logic out_valid;
	logic out_stall = 1'b0;
	logic signed [15:0] roll_deg;
	logic signed [14:0] pitch_deg;
	logic signed [15:0] yaw_deg;
	logic pitch_clamped;

	euler_t angles_due[$];
	int errors = 0;
	bit quiet_tail = 1'b0;
	bit hold_rx = 1'b0;
	bit done_tx = 1'b0;

	always #4 clk = ~clk;

	quaternion_to_euler_angles u_top (.*);

	function automatic longint asr(longint v, int s);
		return v >>> s;
	endfunction

	function automatic longint deg_atan2(longint yy, longint xx);
		longint zz, nx, ny;
		zz = 0;
		if (xx == 0 && yy == 0)
			return 0;
		if (xx < 0) begin
			zz = (yy >= 0) ? (180 <<< 16) : -(180 <<< 16);
			xx = -xx;
			yy = -yy;
		end
		for (int i = 0; i < STAGES && i < TABLE_LEN; i++) begin
			if (yy == 0)
				break;
			if (yy > 0) begin
				nx = xx + asr(yy, i);
				ny = yy - asr(xx, i);
				zz += ATAN_Q16[i];
			end else begin
				nx = xx - asr(yy, i);
				ny = yy + asr(xx, i);
				zz -= ATAN_Q16[i];
			end
			xx = nx;
			yy = ny;
		end
		return zz;
	endfunction

	function automatic longint q7_clip(longint zz, longint lim);
		longint d;
		d = asr(zz + 256, 9);
		if (d > lim)
			d = lim;
		if (d < -lim)
			d = -lim;
		return d;
	endfunction

	function automatic longint floor_sqrt(longint unsigned v);
		longint unsigned r, b;
		r = 0;
		b = 64'd1 << 62;
		while (b > v)
			b >>= 2;
		while (b != 0) begin
			if (v >= r + b) begin
				v -= r + b;
				r = (r >> 1) + b;
			end else begin
				r >>= 1;
			end
			b >>= 2;
		end
		return longint'(r);
	endfunction

	function automatic euler_t quat_to_euler(quat_t q);
		longint x, y, z, w, s, c, one;
		euler_t e;
		x = q.x;
		y = q.y;
		z = q.z;
		w = q.w;
		one = 64'sd1 <<< 28;
		e.roll = 16'(q7_clip(deg_atan2(2 * (w * x + y * z), one - 2 * (x * x + y * y)), 23040));
		e.yaw = 16'(q7_clip(deg_atan2(2 * (w * z + x * y), one - 2 * (y * y + z * z)), 23040));
		s = 2 * (w * y - z * x);
		e.clamp = 1'b0;
		if (s >= one) begin
			e.pitch = 15'sd11520;
			e.clamp = 1'b1;
		end else if (s <= -one) begin
			e.pitch = -15'sd11520;
			e.clamp = 1'b1;
		end else begin
			c = floor_sqrt((64'd1 << 56) - longint'(s * s));
			e.pitch = 15'(q7_clip(deg_atan2(s, c), 11520));
		end
		return e;
	endfunction

	function automatic euler_t ang(int r, int p, int yw, bit cl);
		euler_t e;
		e.roll = 16'(r);
		e.pitch = 15'(p);
		e.yaw = 16'(yw);
		e.clamp = cl;
		return e;
	endfunction

	function automatic row_t mk(int x, int y, int z, int w, bit he, euler_t e);
		row_t r;
		r.q.x = 16'(x);
		r.q.y = 16'(y);
		r.q.z = 16'(z);
		r.q.w = 16'(w);
		r.has_exp = he;
		r.e = e;
		return r;
	endfunction

	function automatic quat_t rand_quat();
		quat_t q;
		int k;
		k = $urandom_range(0, 9);
		if (k < 6) begin
			// component magnitudes sum to 16384 (one in Q14); x and w sometimes redrawn
			int a, b, c, d, m;
			m = $urandom_range(0, 3);
			a = $urandom_range(0, 16384);
			b = $urandom_range(0, 16384 - a);
			c = $urandom_range(0, 16384 - a - b);
			d = 16384 - a - b - c;
			q.x = 16'($urandom_range(0, 1) ? a : -a);
			q.y = 16'($urandom_range(0, 1) ? b : -b);
			q.z = 16'($urandom_range(0, 1) ? c : -c);
			q.w = 16'($urandom_range(0, 1) ? d : -d);
			if (m == 0) begin
				q.x = 16'($urandom_range(0, 32767) - 16384);
				q.w = 16'($urandom_range(0, 32767) - 16384);
			end
		end else if (k < 8) begin
			// gimbal lock neighborhood
			q.w = 16'(11585 + $urandom_range(0, 40) - 20);
			q.y = 16'(($urandom_range(0, 1) ? 1 : -1) * (11585 + $urandom_range(0, 40) - 20));
			q.x = 16'($urandom_range(0, 60) - 30);
			q.z = 16'($urandom_range(0, 60) - 30);
		end else begin
			q.x = 16'($urandom);
			q.y = 16'($urandom);
			q.z = 16'($urandom);
			q.w = 16'($urandom);
		end
		return q;
	endfunction

	task automatic send(quat_t q);
		int gap;
		if (!quiet_tail && $urandom_range(0, 9) == 0) begin
			in_valid <= 1'b0;
			gap = $urandom_range(1, 13);
			repeat (gap) @(negedge clk);
		end
		in_valid <= 1'b1;
		quat_x <= q.x;
		quat_y <= q.y;
		quat_z <= q.z;
		quat_w <= q.w;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		@(negedge clk);
	endtask

	task automatic drain();
		in_valid <= 1'b0;
		while (angles_due.size() != 0)
			@(negedge clk);
	endtask

	always @(posedge clk) begin
		if (arst_n && in_valid && !in_stall)
			angles_due.push_back(quat_to_euler('{quat_x, quat_y, quat_z, quat_w}));
	end

	always @(posedge clk) begin
		euler_t e;
		if (arst_n && out_valid && !out_stall) begin
			if (angles_due.size() == 0) begin
				$display("%0t: unexpected beat roll=%0d pitch=%0d yaw=%0d clamp=%0d", $time,
					roll_deg, pitch_deg, yaw_deg, pitch_clamped);
				errors++;
			end else begin
				e = angles_due.pop_front();
				if (e.roll !== roll_deg) begin
					$display("%0t: roll exp %0d got %0d", $time, e.roll, roll_deg);
					errors++;
				end
				if (e.pitch !== pitch_deg) begin
					$display("%0t: pitch exp %0d got %0d", $time, e.pitch, pitch_deg);
					errors++;
				end
				if (e.yaw !== yaw_deg) begin
					$display("%0t: yaw exp %0d got %0d", $time, e.yaw, yaw_deg);
					errors++;
				end
				if (e.clamp !== pitch_clamped) begin
					$display("%0t: clamp exp %0d got %0d", $time, e.clamp, pitch_clamped);
					errors++;
				end
			end
		end
	end

	// receiver idling
	initial begin
		int n;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (hold_rx) begin
				out_stall <= 1'b1;
				n = 400;
				repeat (n) @(negedge clk);
				out_stall <= 1'b0;
				wait (!hold_rx);
			end else if (!quiet_tail && $urandom_range(0, 7) == 0) begin
				out_stall <= 1'b1;
				n = $urandom_range(1, 13);
				repeat (n - 1) @(negedge clk);
			end else begin
				out_stall <= 1'b0;
			end
		end
	end

	initial begin
		#20ms;
		$display("[FAIL] regression broken");
		$finish;
	end

	initial begin
		row_t rows[$];
		euler_t e0, e;
		e0 = ang(0, 0, 0, 0);
		rows.push_back(mk(0, 0, 0, 16384, 1, e0));
		rows.push_back(mk(0, 0, 0, 0, 1, e0));
		rows.push_back(mk(16384, 0, 0, 0, 1, ang(23040, 0, 0, 0)));
		rows.push_back(mk(0, 0, 16384, 0, 1, ang(0, 0, 23040, 0)));
		rows.push_back(mk(0, 11585, 0, 11585, 0, e0));
		rows.push_back(mk(0, 11586, 0, 11586, 1, ang(23040, 11520, 23040, 1)));
		rows.push_back(mk(0, -11586, 0, 11586, 1, ang(23040, -11520, 23040, 1)));
		rows.push_back(mk(0, 16384, 0, 16384, 0, e0));
		rows.push_back(mk(32767, 32767, 32767, 32767, 0, e0));
		rows.push_back(mk(-32768, -32768, -32768, -32768, 0, e0));
		rows.push_back(mk(-32768, 32767, -32768, 32767, 0, e0));
		rows.push_back(mk(32767, -32768, 0, 0, 0, e0));
		rows.push_back(mk(0, 0, -32768, 32767, 0, e0));
		rows.push_back(mk(-16384, 0, 0, 1, 0, e0));
		rows.push_back(mk(16384, 0, 0, -1, 0, e0));
		rows.push_back(mk(5793, 0, 0, 15137, 0, e0));
		rows.push_back(mk(0, 0, 5793, -15137, 0, e0));
		rows.push_back(mk(1, 1, 1, 1, 0, e0));
		rows.push_back(mk(-1, -1, -1, -1, 0, e0));
		rows.push_back(mk(21845, 10922, -5461, 2730, 0, e0));

		repeat (6) @(negedge clk);
		arst_n <= 1'b1;
		repeat (2) @(negedge clk);

		foreach (rows[i]) begin
			if (rows[i].has_exp) begin
				e = quat_to_euler(rows[i].q);
				if (e.roll !== rows[i].e.roll || e.pitch !== rows[i].e.pitch ||
						e.yaw !== rows[i].e.yaw || e.clamp !== rows[i].e.clamp) begin
					$display("%0t: row %0d table exp r=%0d p=%0d y=%0d c=%0d", $time, i,
						rows[i].e.roll, rows[i].e.pitch, rows[i].e.yaw, rows[i].e.clamp);
					errors++;
				end
			end
			send(rows[i].q);
		end

		for (int i = 0; i < N_RAND; i++) begin
			if (i == 300)
				drain();
			if (i == 500)
				hold_rx = 1'b1;
			if (i == 700)
				hold_rx = 1'b0;
			if (i == N_RAND - 200)
				quiet_tail = 1'b1;
			send(rand_quat());
		end
		in_valid <= 1'b0;
		hold_rx = 1'b0;
		while (angles_due.size() != 0)
			@(negedge clk);
		repeat (STAGES + 40) @(negedge clk);
		if (errors == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

endmodule
